### rtl/sorted_priority_queue_assert.svh
// Assertion macros shared by the sorted priority queue RTL.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define SPQ_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/spq_pkg.sv
// Package with sizes, codes and helpers of the sorted priority queue.
`timescale 1ns / 1ps
package spq_pkg;

  localparam int CAPACITY  = 16;
  localparam int ID_BITS   = 16;
  localparam int PRIO_BITS = 8;
  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int COUNT_W   = $clog2(CAPACITY + 1);

  localparam logic [ADDR_W:0]    CAP_WIDE  = (ADDR_W + 1)'(CAPACITY);
  localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAPACITY);

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [ID_BITS-1:0]   id;
    logic [PRIO_BITS-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic [ID_BITS-1:0]   id;
    logic [PRIO_BITS-1:0] prio;
    logic [1:0]           status;
    logic [COUNT_W-1:0]   count;
  } res_t;

  function automatic logic [ADDR_W-1:0] phys(input logic [ADDR_W-1:0] base,
                                             input logic [ADDR_W-1:0] off);
    logic [ADDR_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= CAP_WIDE) begin
      sum = sum - CAP_WIDE;
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

### rtl/spq_mem.sv
// Entry memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps
module spq_mem (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [spq_pkg::ADDR_W-1:0] wr_addr,
  input  spq_pkg::entry_t            wr_data,
  input  logic                       rd_en,
  input  logic [spq_pkg::ADDR_W-1:0] rd_addr,
  output spq_pkg::entry_t            rd_data
);

  spq_pkg::entry_t mem [spq_pkg::CAPACITY];
  spq_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/spq_ctrl.sv
// Sequencer: circular sorted list over the entry memory, shift-insert scan.
`timescale 1ns / 1ps
module spq_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_mode,
  input  logic [spq_pkg::ID_BITS-1:0]   in_item_id,
  input  logic [spq_pkg::PRIO_BITS-1:0] in_priority_req,
  output logic                          res_valid,
  input  logic                          res_ready,
  output spq_pkg::res_t                 res
);

  `include "sorted_priority_queue_assert.svh"

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_SCAN,
    S_PLACE,
    S_DONE
  } state_t;

  state_t                         state_r, state_nxt;
  logic [spq_pkg::ADDR_W-1:0]     head_r, head_nxt;
  logic [spq_pkg::COUNT_W-1:0]    count_r, count_nxt;
  logic [spq_pkg::ADDR_W-1:0]     wpos_r, wpos_nxt;
  spq_pkg::entry_t                new_r, new_nxt;
  spq_pkg::res_t                  res_r, res_nxt;

  logic                       wr_en;
  logic [spq_pkg::ADDR_W-1:0] wr_addr;
  spq_pkg::entry_t            wr_data;
  logic                       rd_en;
  logic [spq_pkg::ADDR_W-1:0] rd_addr;
  spq_pkg::entry_t            rd_data;

  spq_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    count_nxt = count_r;
    wpos_nxt  = wpos_r;
    new_nxt   = new_r;
    res_nxt   = res_r;
    wr_en     = 1'b0;
    wr_addr   = head_r;
    wr_data   = new_r;
    rd_en     = 1'b0;
    rd_addr   = head_r;
    in_ready  = (state_r == S_IDLE);
    res_valid = (state_r == S_DONE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          new_nxt.id   = in_item_id;
          new_nxt.prio = in_priority_req;
          res_nxt.id   = '0;
          res_nxt.prio = '0;
          res_nxt.status = spq_pkg::ST_OK;
          res_nxt.count  = count_r;
          if (in_mode == spq_pkg::MODE_REMOVE) begin
            if (count_r == '0) begin
              res_nxt.status = spq_pkg::ST_EMPTY;
              state_nxt = S_DONE;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = head_r;
              state_nxt = S_POP;
            end
          end else if (count_r == spq_pkg::CAP_COUNT) begin
            res_nxt.status = spq_pkg::ST_FULL;
            state_nxt = S_DONE;
          end else if (count_r == '0) begin
            wr_en         = 1'b1;
            wr_addr       = head_r;
            wr_data.id    = in_item_id;
            wr_data.prio  = in_priority_req;
            count_nxt     = count_r + 1'b1;
            res_nxt.count = count_nxt;
            state_nxt     = S_DONE;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = spq_pkg::phys(head_r, count_r[spq_pkg::ADDR_W-1:0] - 1'b1);
            wpos_nxt  = count_r[spq_pkg::ADDR_W-1:0];
            state_nxt = S_SCAN;
          end
        end
      end
      S_POP: begin
        res_nxt.id    = rd_data.id;
        res_nxt.prio  = rd_data.prio;
        res_nxt.status = spq_pkg::ST_OK;
        count_nxt     = count_r - 1'b1;
        res_nxt.count = count_nxt;
        head_nxt      = spq_pkg::phys(head_r, spq_pkg::ADDR_W'(1));
        state_nxt     = S_DONE;
      end
      S_SCAN: begin
        wr_en   = 1'b1;
        wr_addr = spq_pkg::phys(head_r, wpos_r);
        if (rd_data.prio >= new_r.prio) begin
          wr_data = rd_data;
          if (wpos_r == spq_pkg::ADDR_W'(1)) begin
            wpos_nxt  = '0;
            state_nxt = S_PLACE;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = spq_pkg::phys(head_r, wpos_r - spq_pkg::ADDR_W'(2));
            wpos_nxt  = wpos_r - 1'b1;
          end
        end else begin
          wr_data       = new_r;
          count_nxt     = count_r + 1'b1;
          res_nxt.count = count_nxt;
          state_nxt     = S_DONE;
        end
      end
      S_PLACE: begin
        wr_en         = 1'b1;
        wr_addr       = spq_pkg::phys(head_r, wpos_r);
        wr_data       = new_r;
        count_nxt     = count_r + 1'b1;
        res_nxt.count = count_nxt;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    wpos_r <= wpos_nxt;
    new_r  <= new_nxt;
    res_r  <= res_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  assign res = res_r;

  `SPQ_ASSERT_ALWAYS(a_count_bound, count_r <= spq_pkg::CAP_COUNT, "entry count over capacity")
  `SPQ_ASSERT_ALWAYS(a_no_same_addr, !(wr_en && rd_en && (wr_addr == rd_addr)), "read and write hit one entry")
  `SPQ_ASSERT_ALWAYS(a_scan_pos, (state_r != S_SCAN) || (wpos_r != '0), "scan at head slot")
  `SPQ_ASSERT_NEXT(a_pop_start, (state_r == S_IDLE) && in_valid && (in_mode == spq_pkg::MODE_REMOVE) && (count_r != '0), state_r == S_POP, "remove did not read head")
  `SPQ_ASSERT_NEXT(a_pop_count, state_r == S_POP, count_r == $past(count_r) - 1'b1, "remove did not drop count")

endmodule

### rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue: sequencer plus output register.
//
// Bounded priority queue of CAPACITY entries kept in ascending priority order.
// Input channel (in_valid/in_ready): in_mode 0 inserts in_item_id with
// in_priority_req ahead of stored entries of equal priority; in_mode 1 removes
// the head entry (lowest priority value). Each transaction yields exactly one
// result transaction on out_valid/out_ready with the removed id and priority
// (zero otherwise), out_status (ok, empty on remove, full on insert) and the
// entry count after the operation.
// An error or an insert into an empty queue goes straight to the result, a
// remove first reads the head entry, and an insert into a non-empty queue
// scans back from the tail, shifting each stored entry of equal or greater
// priority value one slot back; the insert scan moves one memory entry per
// cycle through the single read and write ports. A new transaction is taken
// only once the previous result has entered the output register.
// The output register holds a result while out_ready is low; the block still
// takes the next transaction and parks its result until the register frees.
// Reset (rst_n low, synchronous) empties the queue; memory content is not
// cleared and is never read before it is written.
`timescale 1ns / 1ps
module sorted_priority_queue (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_mode,
  input  logic [spq_pkg::ID_BITS-1:0]     in_item_id,
  input  logic [spq_pkg::PRIO_BITS-1:0]   in_priority_req,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [spq_pkg::ID_BITS-1:0]     out_id,
  output logic [spq_pkg::PRIO_BITS-1:0]   out_priority,
  output logic [1:0]                      out_status,
  output logic [spq_pkg::COUNT_W-1:0]     out_entry_count
);

  logic          res_valid;
  logic          res_ready;
  spq_pkg::res_t res;
  logic          out_valid_r;
  spq_pkg::res_t out_res_r;

  spq_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_item_id      (in_item_id),
    .in_priority_req (in_priority_req),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .res             (res)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_id          = out_res_r.id;
  assign out_priority    = out_res_r.prio;
  assign out_status      = out_res_r.status;
  assign out_entry_count = out_res_r.count;

endmodule
